// ===== rtl/stae_pkg.sv =====
`default_nettype none

package stae_pkg;

  localparam int NameLen         = 13;
  localparam int AttrLen         = 3;
  localparam int HostCapacityDef = 255;

  localparam logic [7:0] ChLt    = 8'h3C;  // '<'
  localparam logic [7:0] ChGt    = 8'h3E;  // '>'
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChDq    = 8'h22;  // '"'
  localparam logic [7:0] ChSq    = 8'h27;  // '\''

  typedef enum logic [1:0] {
    KIND_HOST_BYTE = 2'd0,
    KIND_HOST_DONE = 2'd1,
    KIND_TOO_LONG  = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e      result_kind;
    logic [7:0] host_byte;
    logic [7:0] host_count;
  } result_t;

  typedef struct packed {
    logic finished;
    logic inside_tag;
    logic stream_tag_seen;
  } status_t;

  // "stream:stream", lower case form
  function automatic logic [7:0] name_lo_char(input logic [3:0] p);
    logic [7:0] c;
    case (p)
      4'd0:    c = 8'h73;
      4'd1:    c = 8'h74;
      4'd2:    c = 8'h72;
      4'd3:    c = 8'h65;
      4'd4:    c = 8'h61;
      4'd5:    c = 8'h6D;
      4'd6:    c = 8'h3A;
      4'd7:    c = 8'h73;
      4'd8:    c = 8'h74;
      4'd9:    c = 8'h72;
      4'd10:   c = 8'h65;
      4'd11:   c = 8'h61;
      4'd12:   c = 8'h6D;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // "STREAM:STREAM", upper case form
  function automatic logic [7:0] name_hi_char(input logic [3:0] p);
    logic [7:0] c;
    case (p)
      4'd0:    c = 8'h53;
      4'd1:    c = 8'h54;
      4'd2:    c = 8'h52;
      4'd3:    c = 8'h45;
      4'd4:    c = 8'h41;
      4'd5:    c = 8'h4D;
      4'd6:    c = 8'h3A;
      4'd7:    c = 8'h53;
      4'd8:    c = 8'h54;
      4'd9:    c = 8'h52;
      4'd10:   c = 8'h45;
      4'd11:   c = 8'h41;
      4'd12:   c = 8'h4D;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // "to=" and "TO="
  function automatic logic [7:0] attr_lo_char(input logic [1:0] p);
    logic [7:0] c;
    case (p)
      2'd0:    c = 8'h74;
      2'd1:    c = 8'h6F;
      2'd2:    c = 8'h3D;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] attr_hi_char(input logic [1:0] p);
    logic [7:0] c;
    case (p)
      2'd0:    c = 8'h54;
      2'd1:    c = 8'h4F;
      2'd2:    c = 8'h3D;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/stae_in_if.sv =====
`default_nettype none

interface stae_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_data;

  modport source (output valid, output data_byte, output end_of_data, input ready);
  modport sink   (input valid, input data_byte, input end_of_data, output ready);
endinterface

`default_nettype wire

// ===== rtl/stae_out_if.sv =====
`default_nettype none

interface stae_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] result_kind;
  logic [7:0] host_byte;
  logic [7:0] host_count;

  modport source (output valid, output result_kind, output host_byte, output host_count,
                  input ready);
  modport sink   (input valid, input result_kind, input host_byte, input host_count,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/stream_tag_to_attribute_extractor.sv =====
// A result is registered in the output buffer before it appears on out_o.
// Throughput: one byte per cycle unless the buffer is full; state updates on accept.
// A two-entry result buffer keeps input open while one result waits downstream.
// Reset (rst_ni low, asynchronous): all match flags, the position and the host count
// clear, the buffer empties; after a completion or overflow, bytes are taken and dropped.
`default_nettype none

module stream_tag_to_attribute_extractor import stae_pkg::*; #(
  parameter int HOST_CAPACITY = HostCapacityDef
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  stae_in_if.sink     in_i,
  stae_out_if.source  out_o
);

  logic    accept;
  logic    res_valid;
  result_t res;
  result_t out_data;
  status_t status;
  logic    full;

  assign in_i.ready = !full;
  assign accept     = in_i.valid && in_i.ready;

  stae_parser #(
    .HOST_CAPACITY(HOST_CAPACITY)
  ) u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .data_byte_i   (in_i.data_byte),
    .end_of_data_i (in_i.end_of_data),
    .res_valid_o   (res_valid),
    .res_o         (res),
    .status_o      (status)
  );

  stae_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .full_o      (full),
    .valid_o     (out_o.valid),
    .ready_i     (out_o.ready),
    .data_o      (out_data)
  );

  assign out_o.result_kind = out_data.result_kind;
  assign out_o.host_byte   = out_data.host_byte;
  assign out_o.host_count  = out_data.host_count;

  a_finished_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.finished |=> status.finished)
    else $error("finished flag dropped without reset");

  a_silent_after_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.finished |-> !res_valid)
    else $error("result produced after parsing stopped");

  a_terminal_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && res.result_kind != KIND_HOST_BYTE) |=> status.finished)
    else $error("completion or overflow did not stop the parser");

  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> res.host_count != 8'd0)
    else $error("result carries a zero host count");

  a_capture_in_tag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && res.result_kind == KIND_HOST_BYTE) |->
      (status.inside_tag && status.stream_tag_seen))
    else $error("host byte captured outside a stream tag");

endmodule

`default_nettype wire

// ===== rtl/stae_parser.sv =====
`default_nettype none

module stae_parser import stae_pkg::*; #(
  parameter int HOST_CAPACITY = HostCapacityDef
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       accept_i,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       end_of_data_i,
  output logic            res_valid_o,
  output result_t         res_o,
  output status_t         status_o
);

  localparam logic [7:0] Cap      = 8'(HOST_CAPACITY);
  localparam logic [3:0] NameLast = 4'(NameLen - 1);
  localparam logic [1:0] AttrLast = 2'(AttrLen - 1);

  logic       inside_q, inside_d;
  logic       name_q, name_d;
  logic       seen_q, seen_d;
  logic       attr_q, attr_d;
  logic       capt_q, capt_d;
  logic [3:0] pos_q, pos_d;
  logic [7:0] count_q, count_d;
  logic       finished_q, finished_d;

  logic got, done, too_long, stop;

  always_comb begin
    inside_d   = inside_q;
    name_d     = name_q;
    seen_d     = seen_q;
    attr_d     = attr_q;
    capt_d     = capt_q;
    pos_d      = pos_q;
    count_d    = count_q;
    finished_d = finished_q;
    got        = 1'b0;
    done       = 1'b0;
    too_long   = 1'b0;
    stop       = 1'b0;
    res_valid_o = 1'b0;
    res_o.result_kind = KIND_HOST_BYTE;
    res_o.host_byte   = data_byte_i;
    res_o.host_count  = count_q;

    if (accept_i && !finished_q) begin
      if (!inside_q) begin
        if (data_byte_i == ChLt) begin
          inside_d = 1'b1;
          name_d   = 1'b1;
          seen_d   = 1'b0;
          attr_d   = 1'b0;
          capt_d   = 1'b0;
          pos_d    = '0;
        end
      end else if (data_byte_i == ChGt) begin
        inside_d = 1'b0;
        name_d   = 1'b0;
        attr_d   = 1'b0;
        capt_d   = 1'b0;
        done     = (count_q != 8'd0);
      end else if (data_byte_i == ChSpace && seen_q) begin
        pos_d  = '0;
        attr_d = 1'b1;
        capt_d = 1'b0;
      end else begin
        if (name_q) begin
          if (pos_q > NameLast ||
              (data_byte_i != name_lo_char(pos_q) && data_byte_i != name_hi_char(pos_q))) begin
            name_d = 1'b0;
            stop   = 1'b1;
          end else if (pos_q == NameLast) begin
            seen_d = 1'b1;
            name_d = 1'b0;
            pos_d  = '0;
          end else begin
            pos_d = pos_q + 4'd1;
          end
        end
        if (!stop && seen_d) begin
          if (attr_q) begin
            if (pos_q[3:2] != 2'd0 || pos_q[1:0] > AttrLast ||
                (data_byte_i != attr_lo_char(pos_q[1:0]) &&
                 data_byte_i != attr_hi_char(pos_q[1:0]))) begin
              attr_d = 1'b0;
            end else if (pos_q[1:0] == AttrLast) begin
              capt_d = 1'b1;
              attr_d = 1'b0;
              pos_d  = '0;
            end else begin
              pos_d = pos_q + 4'd1;
            end
          end else if (capt_q && data_byte_i != ChDq && data_byte_i != ChSq) begin
            if (count_q >= Cap) begin
              too_long = 1'b1;
            end else begin
              count_d = count_q + 8'd1;
              got     = 1'b1;
            end
          end
        end
      end

      if (too_long) begin
        // overflow ends parsing at once, end of data is moot
        finished_d        = 1'b1;
        res_valid_o       = 1'b1;
        res_o.result_kind = KIND_TOO_LONG;
        res_o.host_byte   = 8'd0;
        res_o.host_count  = count_q;
      end else begin
        if (end_of_data_i) begin
          finished_d = 1'b1;
          if (count_d != 8'd0) done = 1'b1;
        end
        if (done) begin
          finished_d        = 1'b1;
          res_valid_o       = 1'b1;
          res_o.result_kind = KIND_HOST_DONE;
          res_o.host_byte   = got ? data_byte_i : 8'd0;
          res_o.host_count  = count_d;
        end else if (got) begin
          res_valid_o       = 1'b1;
          res_o.result_kind = KIND_HOST_BYTE;
          res_o.host_count  = count_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inside_q   <= 1'b0;
      name_q     <= 1'b0;
      seen_q     <= 1'b0;
      attr_q     <= 1'b0;
      capt_q     <= 1'b0;
      pos_q      <= '0;
      count_q    <= '0;
      finished_q <= 1'b0;
    end else begin
      inside_q   <= inside_d;
      name_q     <= name_d;
      seen_q     <= seen_d;
      attr_q     <= attr_d;
      capt_q     <= capt_d;
      pos_q      <= pos_d;
      count_q    <= count_d;
      finished_q <= finished_d;
    end
  end

  assign status_o.finished        = finished_q;
  assign status_o.inside_tag      = inside_q;
  assign status_o.stream_tag_seen = seen_q;

endmodule

`default_nettype wire

// ===== rtl/stae_out_buf.sv =====
`default_nettype none

module stae_out_buf import stae_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_i,
  input  wire result_t push_data_i,
  output logic         full_o,
  output logic         valid_o,
  input  wire logic    ready_i,
  output result_t      data_o
);

  result_t    entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q, count_d;
  logic       pop;

  assign pop     = valid_o && ready_i;
  assign valid_o = (count_q != 2'd0);
  assign full_o  = (count_q == 2'd2);
  assign data_o  = entry_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop)      count_d = count_q + 2'd1;
    else if (!push_i && pop) count_d = count_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop)    rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) entry_q[wr_ptr_q] <= push_data_i;
  end

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

import stae_pkg::*;

localparam logic [8*NameLen-1:0] NameLower = "stream:stream";
localparam logic [8*NameLen-1:0] NameUpper = "STREAM:STREAM";
localparam logic [8*AttrLen-1:0] AttrLower = "to=";
localparam logic [8*AttrLen-1:0] AttrUpper = "TO=";
localparam logic [7:0]           ChCr      = 8'h0D;
localparam logic [7:0]           ChLf      = 8'h0A;

function automatic logic [7:0] name_char(int k, bit upper);
  return upper ? NameUpper[8*(NameLen-1-k) +: 8] : NameLower[8*(NameLen-1-k) +: 8];
endfunction

function automatic logic [7:0] attr_char(int k, bit upper);
  return upper ? AttrUpper[8*(AttrLen-1-k) +: 8] : AttrLower[8*(AttrLen-1-k) +: 8];
endfunction

// Tracks the host parse and holds the results still owed by the block.
class host_scoreboard;
  int         capacity;
  bit         in_tag, name_on, tag_seen, attr_on, capturing, stopped;
  logic [3:0] pos;
  logic [7:0] host_len;
  result_t    owed_q[$];
  int         errors;
  int         results;

  function new(int cap);
    capacity = cap;
    pos      = '0;
    host_len = '0;
  endfunction

  function void note_byte(logic [7:0] ch, bit last);
    result_t r;
    bit      got, done, skip;
    got  = 1'b0;
    done = 1'b0;
    skip = 1'b0;
    if (stopped) return;
    if (!in_tag) begin
      if (ch == ChLt) begin
        in_tag    = 1'b1;
        name_on   = 1'b1;
        tag_seen  = 1'b0;
        attr_on   = 1'b0;
        capturing = 1'b0;
        pos       = '0;
      end
    end else if (ch == ChGt) begin
      in_tag    = 1'b0;
      name_on   = 1'b0;
      attr_on   = 1'b0;
      capturing = 1'b0;
      done      = (host_len != 0);
    end else if (ch == ChSpace && tag_seen) begin
      pos       = '0;
      attr_on   = 1'b1;
      capturing = 1'b0;
    end else begin
      if (name_on) begin
        if (pos >= NameLen || (ch != name_char(pos, 1'b0) && ch != name_char(pos, 1'b1))) begin
          name_on = 1'b0;
          skip    = 1'b1;
        end else if (pos == NameLen - 1) begin
          tag_seen = 1'b1;
          name_on  = 1'b0;
          pos      = '0;
        end else begin
          pos = pos + 1'b1;
        end
      end
      if (!tag_seen) skip = 1'b1;
      if (!skip && attr_on) begin
        if (pos >= AttrLen || (ch != attr_char(pos, 1'b0) && ch != attr_char(pos, 1'b1))) begin
          attr_on = 1'b0;
        end else if (pos == AttrLen - 1) begin
          capturing = 1'b1;
          attr_on   = 1'b0;
          pos       = '0;
        end else begin
          pos = pos + 1'b1;
        end
        skip = 1'b1;
      end
      if (!skip && capturing && ch != ChDq && ch != ChSq) begin
        if (host_len >= capacity) begin
          stopped = 1'b1;
          r = '{KIND_TOO_LONG, 8'h00, host_len};
          owed_q.push_back(r);
          return;
        end
        host_len = host_len + 1'b1;
        got      = 1'b1;
      end
    end
    if (last) begin
      stopped = 1'b1;
      if (host_len != 0) done = 1'b1;
    end
    if (done) begin
      stopped = 1'b1;
      r = '{KIND_HOST_DONE, got ? ch : 8'h00, host_len};
      owed_q.push_back(r);
    end else if (got) begin
      r = '{KIND_HOST_BYTE, ch, host_len};
      owed_q.push_back(r);
    end
  endfunction

  function void check_result(logic [1:0] kind, logic [7:0] hb, logic [7:0] hc);
    result_t w;
    results++;
    if (owed_q.size() == 0) begin
      errors++;
      $display("%0t: expected no result, actual kind %0d byte %02h count %0d",
               $time, kind, hb, hc);
      return;
    end
    w = owed_q.pop_front();
    if (w.result_kind !== kind) begin
      errors++;
      $display("%0t: result_kind expected %0d actual %0d", $time, w.result_kind, kind);
    end
    if (w.host_byte !== hb) begin
      errors++;
      $display("%0t: host_byte expected %02h actual %02h", $time, w.host_byte, hb);
    end
    if (w.host_count !== hc) begin
      errors++;
      $display("%0t: host_count expected %0d actual %0d", $time, w.host_count, hc);
    end
  endfunction
endclass

module tb_top;

  localparam int HostCap  = HostCapacityDef;
  localparam int StallMax = 1000;
  localparam int HoldOff  = 150;
  localparam int DrainMax = 2000;

  typedef enum int {END_OVERFLOW, END_CLOSE, END_LAST_HOST, END_LAST_OTHER} ending_e;

  logic clk = 1'b0;
  logic rst_n;

  stae_in_if  in_if();
  stae_out_if out_if();

  stream_tag_to_attribute_extractor #(
    .HOST_CAPACITY(HostCap)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  host_scoreboard sb;
  int             items_sent;
  bit             calm;
  bit             squeeze;

  function automatic logic [7:0] byte_other_than(logic [7:0] a, logic [7:0] b, logic [7:0] c,
                                                 logic [7:0] d);
    logic [7:0] v;
    do v = 8'($urandom_range(255)); while (v == a || v == b || v == c || v == d);
    return v;
  endfunction

  function automatic logic [7:0] host_char();
    return byte_other_than(ChSpace, ChGt, ChDq, ChSq);
  endfunction

  task automatic send_byte(input logic [7:0] b, input bit last = 1'b0);
    while (!calm && $urandom_range(99) < 29) begin
      in_if.valid     <= 1'b0;
      in_if.data_byte <= 8'($urandom_range(255));
      @(negedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.data_byte   <= b;
    in_if.end_of_data <= last;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    sb.note_byte(b, last);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_name(input int n);
    for (int k = 0; k < n; k++) send_byte(name_char(k, 1'($urandom_range(1))));
  endtask

  task automatic send_attr_prefix(input int n);
    for (int k = 0; k < n; k++) send_byte(attr_char(k, 1'($urandom_range(1))));
  endtask

  task automatic send_junk(input int n, input bit with_space);
    repeat (n) send_byte(byte_other_than(ChGt, with_space ? ChGt : ChSpace, ChGt, ChGt));
  endtask

  // Attribute that never captures: broken prefix, quotes only, or a bare space.
  task automatic noise_attr();
    int k;
    send_byte(ChSpace);
    case ($urandom_range(2))
      0: begin
        k = $urandom_range(AttrLen - 1);
        send_attr_prefix(k);
        send_byte(byte_other_than(attr_char(k, 1'b0), attr_char(k, 1'b1), ChSpace, ChGt));
        send_junk($urandom_range(6), 1'b0);
      end
      1: begin
        send_attr_prefix(AttrLen);
        repeat ($urandom_range(3)) send_byte($urandom_range(1) ? ChDq : ChSq);
      end
      default: ;
    endcase
  endtask

  // Capture a host chunk; stop early once the host length reaches the target.
  task automatic host_attr(input int target);
    int         n;
    logic [7:0] b;
    send_byte(ChSpace);
    send_attr_prefix(AttrLen);
    n = $urandom_range(1, 12);
    while (n > 0 && sb.host_len < target) begin
      b = ($urandom_range(7) == 0) ? ($urandom_range(1) ? ChDq : ChSq) : host_char();
      send_byte(b);
      if (b != ChDq && b != ChSq) n--;
    end
  endtask

  // Tags and noise that leave the host length at zero.
  task automatic open_traffic();
    int k;
    case ($urandom_range(5))
      0: repeat ($urandom_range(1, 6)) send_byte(byte_other_than(ChLt, ChLt, ChLt, ChLt));
      1, 2: begin
        send_byte(ChLt);
        k = $urandom_range(NameLen - 1);
        send_name(k);
        send_byte(byte_other_than(name_char(k, 1'b0), name_char(k, 1'b1), ChGt, ChGt));
        send_junk($urandom_range(8), 1'b1);
        send_byte(ChGt);
      end
      default: begin
        send_byte(ChLt);
        send_name(NameLen);
        if ($urandom_range(3) == 0) send_junk($urandom_range(1, 4), 1'b0);
        repeat ($urandom_range(4)) noise_attr();
        send_byte(ChGt);
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready)
      sb.check_result(out_if.result_kind, out_if.host_byte, out_if.host_count);
  end

  initial begin : sink_side
    bit held;
    held         = 1'b0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (squeeze && !held) begin
        // hold off long enough for the result buffer to fill and stall the input
        held = 1'b1;
        out_if.ready <= 1'b0;
        repeat (HoldOff) @(negedge clk);
      end else begin
        out_if.ready <= calm || ($urandom_range(99) >= 29);
      end
    end
  end

  initial begin : watchdog
    int stall;
    stall = 0;
    while (stall < StallMax) begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) stall = 0;
      else stall++;
    end
    $display("%0t: no transaction for %0d cycles", $time, StallMax);
    $display("stream_tag_to_attribute_extractor: mismatch");
    $finish;
  end

  initial begin : source_side
    ending_e how;
    int      target;
    int      b_start;
    int      waited;
    int      pick;
    in_if.valid       = 1'b0;
    in_if.data_byte   = 8'h00;
    in_if.end_of_data = 1'b0;
    rst_n             = 1'b0;
    sb                = new(HostCap);
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // ignored outside a tag, empty tag, mixed-case name with an empty attribute value
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(ChCr);
    send_byte(ChLf);
    send_byte(ChGt);
    send_byte(ChLt);
    send_byte(ChGt);
    send_byte(ChLt);
    for (int k = 0; k < NameLen; k++) send_byte(name_char(k, 1'(k % 2)));
    send_byte(ChSpace);
    for (int k = 0; k < AttrLen; k++) send_byte(attr_char(k, 1'(k % 2)));
    send_byte(ChGt);

    while (items_sent < 1400) open_traffic();

    pick = $urandom_range(9);
    how  = (pick < 4) ? END_OVERFLOW : (pick < 6) ? END_CLOSE :
           (pick < 8) ? END_LAST_HOST : END_LAST_OTHER;
    target = (how == END_OVERFLOW) ? HostCap : $urandom_range(80, HostCap - 1);

    // final tag: capture up to the target, then end the stream
    squeeze = 1'b1;
    b_start = items_sent;
    send_byte(ChLt);
    send_name(NameLen);
    while (sb.host_len < target) begin
      calm = (items_sent >= b_start + 30) && (items_sent < b_start + 200);
      if ($urandom_range(3) == 0) noise_attr();
      else host_attr(target);
    end
    calm = 1'b0;
    case (how)
      END_OVERFLOW:  send_byte(byte_other_than(ChSpace, ChGt, ChDq, ChSq),
                               1'($urandom_range(1)));
      END_CLOSE: begin
        if ($urandom_range(1)) noise_attr();
        send_byte(ChGt);
      end
      END_LAST_HOST: send_byte(host_char(), 1'b1);
      default: begin
        pick = $urandom_range(2);
        send_byte(pick == 0 ? ChSpace : pick == 1 ? ChDq : ChSq, 1'b1);
      end
    endcase

    // block has stopped: everything from here on must be dropped
    send_byte(ChLt);
    send_name(NameLen);
    send_byte(ChSpace);
    send_attr_prefix(AttrLen);
    repeat (12) send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
    in_if.valid <= 1'b0;

    waited = 0;
    while (sb.owed_q.size() != 0 && waited < DrainMax) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (sb.owed_q.size() != 0) begin
      sb.errors += sb.owed_q.size();
      $display("%0t: %0d expected results never arrived", $time, sb.owed_q.size());
    end

    $display("Sent %0d bytes over many tags; checked %0d results, host length %0d.",
             items_sent, sb.results, sb.host_len);
    $display("Stream ended by %s, followed by bytes sent after the stop.", how.name());
    if (sb.errors == 0) begin
      $display("stream_tag_to_attribute_extractor: match");
    end else begin
      $display("stream_tag_to_attribute_extractor: mismatch");
    end
    $finish;
  end

endmodule
